/* sv/sliding_window_median_macros.svh */
// ----------------------------------------------------------------------------
// sliding window median - assertion macros
// shared concurrent check forms, clocked on i_clk and gated by i_rst_n
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

// same-cycle implication
`define SWM_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swm check failed");

// next-cycle implication
`define SWM_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swm next-cycle check failed");

`endif

/* sv/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// constants and types shared by the sliding window median modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swm_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int WIN_BITS    = $clog2(WINDOW_MAX + 1);
    localparam int IDX_BITS    = $clog2(WINDOW_MAX);
    localparam int TOTAL_BITS  = 48;

    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX  = {TOTAL_BITS{1'b1}};
    localparam logic [WIN_BITS-1:0]   WIN_RESET  = WIN_BITS'(3);
    localparam logic [WIN_BITS-1:0]   WIN_LIMIT  = WIN_BITS'(WINDOW_MAX);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_status;

endpackage

/* sv/swm_ctrl.sv */
// ----------------------------------------------------------------------------
// swm_ctrl
// sequencer: accept a beat, run the sorted-store merge pass, post the result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  swm_pkg::t_status i_status,
    output swm_pkg::t_cmd    o_cmd
);

    swm_pkg::t_state r_state;
    swm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        unique case (r_state)
            swm_pkg::ST_IDLE: begin
                // sample side held off while reset is applied
                if (i_rst_n) begin
                    o_in_stall = 1'b0;
                    if (i_in_valid) begin
                        o_cmd.start = 1'b1;
                        n_state     = swm_pkg::ST_SCAN;
                    end
                end
            end
            swm_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = swm_pkg::ST_FINISH;
                end
            end
            swm_pkg::ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = swm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/swm_datapath.sv */
// ----------------------------------------------------------------------------
// swm_datapath
// history ring, sorted store with merge pass, running total, output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_median_macros.svh"

module swm_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  swm_pkg::t_cmd                       i_cmd,
    output swm_pkg::t_status                    o_status,
    input  logic                                i_cfg_wr_en,
    input  logic [swm_pkg::WIN_BITS-1:0]        i_cfg_wr_data,
    input  logic [swm_pkg::SAMPLE_BITS-1:0]     i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [swm_pkg::SAMPLE_BITS-1:0]     o_median,
    output logic                                o_window_full,
    output logic [swm_pkg::TOTAL_BITS-1:0]      o_median_total
);

    // memories
    logic [swm_pkg::SAMPLE_BITS-1:0] hist_mem   [swm_pkg::WINDOW_MAX];
    logic [swm_pkg::SAMPLE_BITS-1:0] sorted_mem [swm_pkg::WINDOW_MAX];
    logic [swm_pkg::SAMPLE_BITS-1:0] r_hist_q;
    logic [swm_pkg::SAMPLE_BITS-1:0] r_sort_q;

    // window state
    logic [swm_pkg::WIN_BITS-1:0]   r_win;
    logic [swm_pkg::WIN_BITS-1:0]   r_fill;
    logic [swm_pkg::IDX_BITS-1:0]   r_ptr;
    logic [swm_pkg::TOTAL_BITS-1:0] r_total;

    // merge pass
    logic [swm_pkg::WIN_BITS-1:0]    r_rd_idx;
    logic [swm_pkg::WIN_BITS-1:0]    r_wr_idx;
    logic [swm_pkg::WIN_BITS-1:0]    r_n;
    logic                            r_removed;
    logic                            r_full_after;
    logic [swm_pkg::SAMPLE_BITS-1:0] r_carry;
    logic [swm_pkg::SAMPLE_BITS-1:0] r_med;

    // output register
    logic                            r_out_valid;
    logic [swm_pkg::SAMPLE_BITS-1:0] r_out_median;
    logic                            r_out_full;
    logic [swm_pkg::TOTAL_BITS-1:0]  r_out_total;

    logic [swm_pkg::WIN_BITS-1:0]    w_eff;
    logic [swm_pkg::WIN_BITS:0]      w_p1;
    logic [swm_pkg::WIN_BITS-1:0]    mid_idx;
    logic                            full_now;
    logic [swm_pkg::WIN_BITS-1:0]    fill_p1;
    logic [swm_pkg::WIN_BITS-1:0]    ptr_p1;
    logic [swm_pkg::IDX_BITS-1:0]    hist_waddr;
    logic                            elem_valid;
    logic                            skip;
    logic                            sort_we;
    logic [swm_pkg::SAMPLE_BITS-1:0] sort_wdata;
    logic                            sort_re;
    logic [swm_pkg::IDX_BITS-1:0]    sort_raddr;
    logic [swm_pkg::SAMPLE_BITS-1:0] lo_val;
    logic [swm_pkg::SAMPLE_BITS-1:0] hi_val;
    logic [swm_pkg::TOTAL_BITS:0]    sum;
    logic [swm_pkg::TOTAL_BITS-1:0]  n_total;

    // clamp window to 1..max
    always_comb begin
        priority if (r_win == '0) begin
            w_eff = swm_pkg::WIN_BITS'(1);
        end else if (r_win > swm_pkg::WIN_LIMIT) begin
            w_eff = swm_pkg::WIN_LIMIT;
        end else begin
            w_eff = r_win;
        end
    end

    assign w_p1       = {1'b0, w_eff} + 1'b1;
    assign mid_idx    = w_p1[swm_pkg::WIN_BITS:1] - 1'b1;
    assign full_now   = (r_fill >= w_eff);
    assign fill_p1    = r_fill + 1'b1;
    assign ptr_p1     = {1'b0, r_ptr} + 1'b1;
    assign hist_waddr = full_now ? r_ptr : r_fill[swm_pkg::IDX_BITS-1:0];

    // element rd_idx-1 sits in r_sort_q during the scan
    assign elem_valid = (r_rd_idx <= r_n);
    assign skip       = elem_valid && !r_removed && (r_sort_q == r_hist_q);
    assign lo_val     = (r_sort_q < r_carry) ? r_sort_q : r_carry;
    assign hi_val     = (r_sort_q < r_carry) ? r_carry : r_sort_q;
    assign sort_we    = i_cmd.scan && !skip;
    assign sort_wdata = elem_valid ? lo_val : r_carry;
    assign sort_re    = i_cmd.start || i_cmd.scan;
    assign sort_raddr = i_cmd.start ? '0 : r_rd_idx[swm_pkg::IDX_BITS-1:0];

    assign sum = {1'b0, r_total} + (swm_pkg::TOTAL_BITS+1)'(r_med);
    always_comb begin
        n_total = r_total;
        if (r_full_after) begin
            n_total = sum[swm_pkg::TOTAL_BITS] ? swm_pkg::TOTAL_MAX
                                              : sum[swm_pkg::TOTAL_BITS-1:0];
        end
    end

    assign o_status.scan_done = i_cmd.scan && !elem_valid;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    // history ring: old entry read while the new sample lands
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_hist_q              <= hist_mem[r_ptr];
            hist_mem[hist_waddr]  <= i_sample;
        end
    end

    // sorted store
    always_ff @(posedge i_clk) begin
        if (sort_re) begin
            r_sort_q <= sorted_mem[sort_raddr];
        end
        if (sort_we) begin
            sorted_mem[r_wr_idx[swm_pkg::IDX_BITS-1:0]] <= sort_wdata;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_carry <= i_sample;
        end else if (i_cmd.scan && elem_valid && !skip) begin
            r_carry <= hi_val;
        end
        if (sort_we && (r_wr_idx == mid_idx)) begin
            r_med <= sort_wdata;
        end
        if (i_cmd.finish) begin
            r_out_median <= r_full_after ? r_med : '0;
            r_out_full   <= r_full_after;
            r_out_total  <= n_total;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win        <= swm_pkg::WIN_RESET;
            r_fill       <= '0;
            r_ptr        <= '0;
            r_total      <= '0;
            r_rd_idx     <= '0;
            r_wr_idx     <= '0;
            r_n          <= '0;
            r_removed    <= 1'b1;
            r_full_after <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_win  <= i_cfg_wr_data;
                r_fill <= '0;
                r_ptr  <= '0;
            end else if (i_cmd.start) begin
                if (full_now) begin
                    r_ptr <= (ptr_p1 == w_eff) ? '0 : ptr_p1[swm_pkg::IDX_BITS-1:0];
                end else begin
                    r_fill <= fill_p1;
                    r_ptr  <= '0;
                end
            end

            if (i_cmd.start) begin
                r_rd_idx     <= swm_pkg::WIN_BITS'(1);
                r_wr_idx     <= '0;
                r_n          <= full_now ? w_eff : r_fill;
                r_removed    <= !full_now;
                r_full_after <= full_now || (fill_p1 >= w_eff);
            end else if (i_cmd.scan) begin
                if (elem_valid) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
                if (skip) begin
                    r_removed <= 1'b1;
                end
                if (sort_we) begin
                    r_wr_idx <= r_wr_idx + 1'b1;
                end
            end

            if (i_cmd.finish) begin
                r_total     <= n_total;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_median       = r_out_median;
    assign o_window_full  = r_out_full;
    assign o_median_total = r_out_total;

    // the merge never writes ahead of what it has read
    `SWM_CHECK(a_wr_behind_rd, 1'b1, r_wr_idx <= r_rd_idx)
    // a pass writes exactly one entry per window sample (one removed, one added)
    `SWM_CHECK(a_pass_count, i_cmd.finish, r_wr_idx == r_fill)
    `SWM_CHECK(a_window_bounds, 1'b1, (r_fill <= w_eff) && ({1'b0, r_ptr} < w_eff))
    `SWM_CHECK_NEXT(a_total_monotone, 1'b1, r_total >= $past(r_total))

endmodule

/* sv/sliding_window_median.sv */
// ----------------------------------------------------------------------------
// sliding_window_median
// lower median over the last window_size samples with a saturating total
// ----------------------------------------------------------------------------
// One 16-bit sample per input beat; each beat yields one result beat with
// the lower median of the current window (zero until the window is full),
// a window-full flag and the 48-bit saturating total of all medians so far.
// Each result comes from a merge pass over the samples already held in the
// sorted store (window_size once the window is full, the fill count while
// it is filling), a memory read one entry ahead and rewritten one entry per
// cycle, which drops the oldest sample and slots in the new one in the same
// sweep. The input stalls for the whole pass; a finished result waits in
// the output register, and the next sample is accepted meanwhile. Writing
// window_size (idle only) restarts the window from empty and keeps the
// total. No clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_median (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_wr_en,
    input  logic [swm_pkg::WIN_BITS-1:0]    i_cfg_wr_data,
    // sample channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [swm_pkg::SAMPLE_BITS-1:0] i_sample,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [swm_pkg::SAMPLE_BITS-1:0] o_median,
    output logic                            o_window_full,
    output logic [swm_pkg::TOTAL_BITS-1:0]  o_median_total
);

    swm_pkg::t_cmd    cmd;
    swm_pkg::t_status status;

    // sequencer: idle -> merge scan -> post result
    swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // storage, merge, total and output register
    swm_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_median       (o_median),
        .o_window_full  (o_window_full),
        .o_median_total (o_median_total)
    );

endmodule

/* bench/sliding_window_median_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_test
// self-checking bench for the sliding window lower-median filter
// ----------------------------------------------------------------------------
// Sample beats go in through the valid/stall channel and every result beat is
// compared field by field with a scoreboard fed by a behavioral model. The
// model keeps its own history ring, a sorted copy of the window and the
// saturating total. A short directed opening covers the reset window, single
// sample windows (one written as zero) and duplicate values. It is followed
// by random phases over many window sizes, clamped ones included, a long
// output hold-off that backs the block up, and a final stretch at full rate.
// ----------------------------------------------------------------------------

module sliding_window_median_test;

    localparam int CLK_PERIOD     = 10;
    localparam int IDLE_LIMIT     = 2000;           // cycles with no beat on either side
    localparam int HOLD_CYCLES    = 300;            // long output hold-off
    localparam int DRAIN_CYCLES   = swm_pkg::WINDOW_MAX + 8; // slowest pass plus margin
    localparam int RANDOM_SAMPLES = 1100;
    localparam logic [swm_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    // one result beat as the block should present it
    typedef struct packed {
        logic [swm_pkg::SAMPLE_BITS-1:0] median;
        logic                            window_full;
        logic [swm_pkg::TOTAL_BITS-1:0]  total;
    } t_median_beat;

    // dut ports, all inputs known from time zero
    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_wr_en   = 1'b0;
    logic [swm_pkg::WIN_BITS-1:0]    i_cfg_wr_data = '0;
    logic                            i_in_valid    = 1'b0;
    logic                            o_in_stall;
    logic [swm_pkg::SAMPLE_BITS-1:0] i_sample      = '0;
    logic                            o_out_valid;
    logic                            i_out_stall   = 1'b0;
    logic [swm_pkg::SAMPLE_BITS-1:0] o_median;
    logic                            o_window_full;
    logic [swm_pkg::TOTAL_BITS-1:0]  o_median_total;

    // behavioral copy of the filter state
    logic [swm_pkg::SAMPLE_BITS-1:0] hist_ring [swm_pkg::WINDOW_MAX];
    logic [swm_pkg::SAMPLE_BITS-1:0] sorted_window [$];
    int unsigned                     fill_cnt      = 0;
    int unsigned                     oldest_idx    = 0;
    logic [swm_pkg::TOTAL_BITS-1:0]  running_total = '0;
    logic [swm_pkg::WIN_BITS-1:0]    win_reg       = swm_pkg::WIN_RESET;

    // medians still owed by the block, oldest first
    t_median_beat pending_medians [$];

    // run bookkeeping
    int unsigned samples_sent    = 0;
    int unsigned medians_checked = 0;
    int unsigned full_medians    = 0;
    int unsigned mismatch_count  = 0;
    int unsigned window_writes   = 0;

    // idling controls shared with the driver processes
    bit          tx_idle_on   = 1'b1;
    bit          rx_idle_on   = 1'b1;
    int unsigned hold_request = 0;

    sliding_window_median dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_median       (o_median),
        .o_window_full  (o_window_full),
        .o_median_total (o_median_total)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // behavioral filter
    // ------------------------------------------------------------------------

    // zero behaves as one, anything past the store depth as the full depth
    function automatic int unsigned active_window(
        input logic [swm_pkg::WIN_BITS-1:0] raw
    );
        if (raw == '0) begin
            return 1;
        end
        if (raw > swm_pkg::WINDOW_MAX) begin
            return swm_pkg::WINDOW_MAX;
        end
        return int'(raw);
    endfunction

    // advance the window by one sample and queue the median it yields
    task automatic predict_median(input logic [swm_pkg::SAMPLE_BITS-1:0] s);
        int unsigned                     w;
        int unsigned                     slot;
        int                              pos;
        logic [swm_pkg::SAMPLE_BITS-1:0] evicted;
        logic [swm_pkg::TOTAL_BITS:0]    sum;
        t_median_beat                    beat;
        w = active_window(win_reg);
        if (fill_cnt >= w) begin
            // steady state: drop one copy of the oldest value, then slot in the new one
            slot    = oldest_idx % w;
            evicted = hist_ring[slot];
            pos     = 0;
            while (pos < sorted_window.size() && sorted_window[pos] != evicted) begin
                pos++;
            end
            if (pos < sorted_window.size()) begin
                sorted_window.delete(pos);
            end
            hist_ring[slot] = s;
            oldest_idx      = (slot + 1) % w;
        end else begin
            // still filling: append only
            hist_ring[fill_cnt] = s;
            fill_cnt++;
            oldest_idx = 0;
        end
        pos = sorted_window.size();
        while (pos > 0 && sorted_window[pos-1] > s) begin
            pos--;
        end
        sorted_window.insert(pos, s);

        beat = '0;
        if (fill_cnt >= w) begin
            beat.window_full = 1'b1;
            beat.median      = sorted_window[(w + 1) / 2 - 1];
            sum              = {1'b0, running_total} + beat.median;
            // total sticks at all ones once it would wrap
            running_total    = sum[swm_pkg::TOTAL_BITS] ? swm_pkg::TOTAL_MAX
                                                        : sum[swm_pkg::TOTAL_BITS-1:0];
        end
        beat.total = running_total;
        pending_medians.insert(pending_medians.size(), beat);
    endtask

    // ------------------------------------------------------------------------
    // sample side
    // ------------------------------------------------------------------------

    // offer one sample beat, with an occasional idle burst ahead of it;
    // valid is left high so back-to-back beats stay back to back
    task automatic send_sample(input logic [swm_pkg::SAMPLE_BITS-1:0] s);
        int unsigned gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
        end
        if (gap != 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_sample   <= s;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) begin
                break;
            end
        end
        predict_median(s);
        samples_sent++;
    endtask

    // drop valid and wait until every owed median has come out
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_medians.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // window writes only happen with the block idle; the window restarts empty
    task automatic write_window(input logic [swm_pkg::WIN_BITS-1:0] w);
        drain_results();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        win_reg    = w;
        fill_cnt   = 0;
        oldest_idx = 0;
        sorted_window.delete();
        window_writes++;
    endtask

    // half full-range noise, with clusters and heavy repeats mixed in
    function automatic logic [swm_pkg::SAMPLE_BITS-1:0] pick_sample(
        input logic [swm_pkg::SAMPLE_BITS-1:0] center
    );
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                return swm_pkg::SAMPLE_BITS'($urandom);
            end
            5, 6: begin
                return center + swm_pkg::SAMPLE_BITS'($urandom_range(0, 3));
            end
            7: begin
                return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : '0;
            end
            default: begin
                return center + swm_pkg::SAMPLE_BITS'($urandom_range(0, 255))
                              - swm_pkg::SAMPLE_BITS'(128);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    // output stall: random bursts, or one long hold on request
    initial begin : out_stall_driver
        int unsigned burst_left;
        int unsigned hold_left;
        logic        next_stall;
        burst_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                next_stall = 1'b1;
                hold_left--;
            end else if (burst_left != 0) begin
                next_stall = 1'b1;
                burst_left--;
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                next_stall = 1'b1;
                burst_left = $urandom_range(0, 5);
            end else begin
                next_stall = 1'b0;
            end
            i_out_stall <= next_stall;
        end
    end

    // compare every accepted result beat against the oldest owed median
    initial begin : median_checker
        t_median_beat want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (pending_medians.size() == 0) begin
                    $display("%0t: unexpected result beat: median %h full %b total %h",
                             $time, o_median, o_window_full, o_median_total);
                    mismatch_count++;
                end else begin
                    want = pending_medians.pop_front();
                    medians_checked++;
                    if (want.window_full) begin
                        full_medians++;
                    end
                    if (o_median !== want.median) begin
                        $display("%0t: median mismatch: expected %h, actual %h",
                                 $time, want.median, o_median);
                        mismatch_count++;
                    end
                    if (o_window_full !== want.window_full) begin
                        $display("%0t: window_full mismatch: expected %b, actual %b",
                                 $time, want.window_full, o_window_full);
                        mismatch_count++;
                    end
                    if (o_median_total !== want.total) begin
                        $display("%0t: median_total mismatch: expected %h, actual %h",
                                 $time, want.total, o_median_total);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // give up when neither channel has moved a beat for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: watchdog: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("sliding_window_median regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // window of three from reset: extremes, repeats, no register write yet
    task automatic test_reset_window();
        send_sample(SAMPLE_MAX);
        send_sample('0);
        send_sample(16'h8000);
        send_sample(16'h0001);
        send_sample(16'h7FFF);
        send_sample(16'h0005);
        send_sample(16'h0005);
        send_sample(16'h0005);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
    endtask

    // window of one, then a zero write that must behave as one
    task automatic test_single_sample_window();
        write_window(swm_pkg::WIN_BITS'(1));
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(16'h1234);
        write_window('0);
        send_sample(16'hABCD);
        send_sample('0);
    endtask

    // repeated values so the eviction has to pick one copy out of several
    task automatic test_duplicate_values();
        write_window(swm_pkg::WIN_BITS'(4));
        send_sample(16'h0007);
        send_sample(16'h0007);
        send_sample(16'h0003);
        send_sample(16'h0007);
        send_sample(16'h0007);
        send_sample(16'h0009);
        send_sample(16'h0007);
        send_sample(16'h0003);
    endtask

    // phases over many window sizes, including the clamped ones above the depth
    task automatic test_random_windows();
        logic [swm_pkg::WIN_BITS-1:0]    fixed_windows [7] = '{7'd64, 7'd127, 7'd65, 7'd2,
                                                               7'd5, 7'd16, 7'd33};
        int unsigned                     phase;
        int unsigned                     sent;
        int unsigned                     count;
        logic [swm_pkg::WIN_BITS-1:0]    w;
        logic [swm_pkg::SAMPLE_BITS-1:0] center;
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_SAMPLES) begin
            if (phase < 7) begin
                w = fixed_windows[phase];
            end else if ($urandom_range(0, 3) == 0) begin
                w = swm_pkg::WIN_BITS'($urandom_range(0, 127));
            end else begin
                // keep most phases short so the run stays fast
                w = swm_pkg::WIN_BITS'($urandom_range(1, 12));
            end
            // some phases run without any idling at all
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            write_window(w);
            count  = 2 * active_window(w) + $urandom_range(5, 40);
            center = swm_pkg::SAMPLE_BITS'($urandom);
            repeat (count) send_sample(pick_sample(center));
            sent += count;
            phase++;
        end
    endtask

    // hold the output off for a long stretch while samples keep coming,
    // so the result register fills and the sample side has to stall
    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        write_window(swm_pkg::WIN_BITS'(8));
        hold_request = HOLD_CYCLES;
        repeat (24) send_sample(swm_pkg::SAMPLE_BITS'($urandom));
    endtask

    // closing stretch at full rate, no idling on either side
    task automatic test_steady_stream();
        logic [swm_pkg::SAMPLE_BITS-1:0] center;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_window(swm_pkg::WIN_BITS'(12));
        center = swm_pkg::SAMPLE_BITS'($urandom);
        repeat (80) send_sample(pick_sample(center));
    endtask

    initial begin
        // synchronous reset, held low from time zero
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_window();
        test_single_sample_window();
        test_duplicate_values();
        test_random_windows();
        test_output_backpressure();
        test_steady_stream();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d samples over %0d window writes, %0d medians checked (%0d full)",
                 samples_sent, window_writes, medians_checked, full_medians);
        $display("included a %0d-cycle output hold-off and a full-rate closing stretch",
                 HOLD_CYCLES);
        if (mismatch_count == 0 && pending_medians.size() == 0) begin
            $display("sliding_window_median regression: pass");
        end else begin
            $display("%0d mismatches, %0d medians never seen",
                     mismatch_count, pending_medians.size());
            $display("sliding_window_median regression: fail");
        end
        $finish;
    end

endmodule
